### rtl/swlv_pkg.sv
// Shared types and constants of the sliding window label vote unit.
package swlv_pkg;

    localparam int WINDOW_LEN  = 30;
    localparam int LABEL_W     = 4;
    localparam int LABEL_COUNT = 1 << LABEL_W;
    localparam int SCORE_W     = 17;
    localparam int SCORE_ONE   = 65536;
    localparam int VOTES_W     = 5;
    localparam int QUEUE_DEPTH = 4;

    localparam int SLOT_W  = $clog2(WINDOW_LEN);
    localparam int FILL_W  = $clog2(WINDOW_LEN + 1);
    localparam int CNT_W   = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W   = $clog2(WINDOW_LEN * SCORE_ONE + 1);
    localparam int PROD_W  = SCORE_W + CNT_W;
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_DATA_W  = ((LABEL_W + SCORE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((LABEL_W + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 8;

    localparam logic [SCORE_W-1:0] THRESH_RESET = SCORE_W'(55706);
    localparam logic [VOTES_W-1:0] VOTES_RESET  = VOTES_W'(25);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOTES       = CFG_IDX_W'(1);

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [SCORE_W-1:0] score;
    } t_item;

endpackage

### rtl/swlv_front.sv
// Input stage: takes classifier results, saturates the score, registers the item.
module swlv_front
    import swlv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [LABEL_W-1:0]   i_label,
    input  logic [SCORE_W-1:0]   i_score,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_item                o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    t_item w_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        w_item.label = i_label;
        // scores above 1.0 are clipped so the per-label sums stay bounded
        w_item.score = (i_score > SCORE_W'(SCORE_ONE)) ? SCORE_W'(SCORE_ONE) : i_score;
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= w_item;
        end
    end

endmodule

### rtl/swlv_queue.sv
// Short FIFO between the input stage and the vote engine.
module swlv_queue
    import swlv_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_item,
    output logic   o_ready,
    output logic   o_valid,
    output t_item  o_item,
    input  logic   i_pop
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;
    logic              w_push;
    logic              w_pop;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### rtl/swlv_back.sv
// Vote engine: window store, per-label histograms, argmax, threshold test, result register.
module swlv_back
    import swlv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [SCORE_W-1:0]    i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_pop,
    input  t_item                 i_item,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_recognized,
    output logic [LABEL_W-1:0]    o_label
);

    logic [SCORE_W-1:0] r_thresh;
    logic [VOTES_W-1:0] r_min_votes;

    logic [LABEL_W-1:0] r_win_lab [WINDOW_LEN];
    logic [SCORE_W-1:0] r_win_sc  [WINDOW_LEN];
    logic [FILL_W-1:0]  r_fill;
    logic [SLOT_W-1:0]  r_oldest;
    logic [CNT_W-1:0]   r_cnt [LABEL_COUNT];
    logic [SUM_W-1:0]   r_sum [LABEL_COUNT];
    logic [CNT_W-1:0]   n_cnt [LABEL_COUNT];
    logic [SUM_W-1:0]   n_sum [LABEL_COUNT];

    logic               r_out_valid;
    logic               r_out_rec;
    logic [LABEL_W-1:0] r_out_lab;

    logic               w_fire;
    logic               w_filling;
    logic [LABEL_W-1:0] w_old_lab;
    logic [SCORE_W-1:0] w_old_sc;
    logic [SLOT_W-1:0]  w_slot;

    // argmax tree, heap order: node n has children 2n and 2n+1
    logic [CNT_W-1:0]   w_tree_cnt [1:2*LABEL_COUNT-1];
    logic [LABEL_W-1:0] w_tree_idx [1:2*LABEL_COUNT-1];
    logic [CNT_W-1:0]   w_best_cnt;
    logic [LABEL_W-1:0] w_best;
    logic [SUM_W-1:0]   w_best_sum;
    logic [PROD_W-1:0]  w_need;
    logic               w_hit;

    assign w_fire    = i_valid && (!r_out_valid || i_ready);
    assign o_pop     = w_fire;
    assign w_filling = (r_fill != FILL_W'(WINDOW_LEN));
    assign w_old_lab = r_win_lab[r_oldest];
    assign w_old_sc  = r_win_sc[r_oldest];
    assign w_slot    = w_filling ? r_fill[SLOT_W-1:0] : r_oldest;

    always_comb begin
        for (int i = 0; i < LABEL_COUNT; i++) begin
            logic w_inc;
            logic w_dec;
            w_inc = (i_item.label == LABEL_W'(i));
            w_dec = !w_filling && (w_old_lab == LABEL_W'(i));
            n_cnt[i] = r_cnt[i] + CNT_W'(w_inc) - CNT_W'(w_dec);
            n_sum[i] = r_sum[i] + (w_inc ? SUM_W'(i_item.score) : '0)
                                - (w_dec ? SUM_W'(w_old_sc) : '0);
        end
    end

    always_comb begin
        for (int i = 0; i < LABEL_COUNT; i++) begin
            w_tree_cnt[LABEL_COUNT + i] = n_cnt[i];
            w_tree_idx[LABEL_COUNT + i] = LABEL_W'(i);
        end
        // right child wins only on a strictly larger count: lowest index wins ties
        for (int n = LABEL_COUNT - 1; n >= 1; n--) begin
            if (w_tree_cnt[2*n+1] > w_tree_cnt[2*n]) begin
                w_tree_cnt[n] = w_tree_cnt[2*n+1];
                w_tree_idx[n] = w_tree_idx[2*n+1];
            end else begin
                w_tree_cnt[n] = w_tree_cnt[2*n];
                w_tree_idx[n] = w_tree_idx[2*n];
            end
        end
        w_best_cnt = w_tree_cnt[1];
        w_best     = w_tree_idx[1];
    end

    assign w_best_sum = n_sum[w_best];
    assign w_need     = PROD_W'(r_thresh) * PROD_W'(w_best_cnt);
    assign w_hit      = !w_filling && (w_best_cnt != '0)
                        && (CNT_W'(w_best_cnt) >= CNT_W'(r_min_votes))
                        && (PROD_W'(w_best_sum) >= w_need);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh    <= THRESH_RESET;
            r_min_votes <= VOTES_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SCORE_THRESHOLD: r_thresh    <= i_cfg_data;
                CFG_MIN_VOTES:       r_min_votes <= i_cfg_data[VOTES_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_oldest <= '0;
            for (int i = 0; i < LABEL_COUNT; i++) begin
                r_cnt[i] <= '0;
                r_sum[i] <= '0;
            end
        end else if (w_fire) begin
            if (w_hit) begin
                r_fill   <= '0;
                r_oldest <= '0;
                for (int i = 0; i < LABEL_COUNT; i++) begin
                    r_cnt[i] <= '0;
                    r_sum[i] <= '0;
                end
            end else begin
                for (int i = 0; i < LABEL_COUNT; i++) begin
                    r_cnt[i] <= n_cnt[i];
                    r_sum[i] <= n_sum[i];
                end
                if (w_filling) begin
                    r_fill <= r_fill + 1'b1;
                end else begin
                    r_oldest <= (r_oldest == SLOT_W'(WINDOW_LEN - 1)) ? '0 : r_oldest + 1'b1;
                end
            end
        end
    end

    // entries are only read after being written, so no reset here
    always_ff @(posedge i_clk) begin
        if (w_fire && !w_hit) begin
            r_win_lab[w_slot] <= i_item.label;
            r_win_sc[w_slot]  <= i_item.score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_rec <= w_hit;
            r_out_lab <= w_hit ? w_best : '0;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_recognized = r_out_rec;
    assign o_label      = r_out_lab;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WINDOW_LEN))
        else $error("window fill count overran the window length");

    a_oldest_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_filling |-> (r_oldest == '0))
        else $error("replacement pointer moved while the window was filling");

    a_hit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_hit) |=> (r_fill == '0 && r_oldest == '0))
        else $error("window not emptied after a recognition");

    a_no_vote_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_filling) |=> !r_out_rec)
        else $error("recognition reported on a filling transaction");

endmodule

### rtl/sliding_window_label_vote_unit.sv
// Sliding window label vote unit: top level.
// Takes one classifier result (label, score) per transaction and returns exactly one
// result per transaction. Sustained rate is one transaction per clock while the
// output side is not stalled. The accepting edge loads the input register, the item
// is then written into the queue, and the vote engine pops it from the queue and
// loads the result register. The rate is set by the vote engine, which updates all
// label histograms, picks the most frequent label and applies the count and
// average-score test for each transaction it accepts, with no busy state. A four-entry
// queue sits between the input register and the vote engine so that each side can
// stall on its own. The user must write configuration registers through the cfg
// channel only while no transaction is in flight; the block itself does not enforce
// this. The cfg channel is always ready.
module sliding_window_label_vote_unit
    import swlv_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_DATA_W-1:0]   i_s_tdata,    // [3:0] label, [20:4] score, rest zero
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_DATA_W-1:0]  o_m_tdata,    // [3:0] recognized_label, rest zero
    output logic                   o_m_tuser,    // [0] recognized
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [SCORE_W-1:0]     i_cfg_data
);

    logic               w_front_valid;
    logic               w_front_ready;
    t_item              w_front_item;
    logic               w_q_valid;
    t_item              w_q_item;
    logic               w_q_pop;
    logic               w_recognized;
    logic [LABEL_W-1:0] w_rec_label;

    assign o_cfg_ready = 1'b1;

    swlv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_label (i_s_tdata[LABEL_W-1:0]),
        .i_score (i_s_tdata[LABEL_W+SCORE_W-1:LABEL_W]),
        .o_valid (w_front_valid),
        .i_ready (w_front_ready),
        .o_item  (w_front_item)
    );

    swlv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_item  (w_front_item),
        .o_ready (w_front_ready),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_q_pop)
    );

    swlv_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (w_q_valid),
        .o_pop        (w_q_pop),
        .i_item       (w_q_item),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_recognized (w_recognized),
        .o_label      (w_rec_label)
    );

    assign o_m_tdata = OUT_DATA_W'(w_rec_label);
    assign o_m_tuser = w_recognized;

endmodule

### tb/sv/sliding_window_label_vote_unit_test.sv
// Self-checking testbench for the sliding window label vote unit.
`timescale 1ns / 100ps

module sliding_window_label_vote_unit_test
    import swlv_pkg::*;
();

    localparam int                   NUM_PHASES  = 8;
    localparam int                   PHASE_ITEMS = 200;
    localparam int                   CYCLE_LIMIT = 400000;
    localparam int                   MAX_REPORTS = 10;
    localparam int                   SCORE_MAX   = (1 << SCORE_W) - 1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = CFG_IDX_W'(7);

    typedef struct packed {
        logic               recognized;
        logic [LABEL_W-1:0] label;
    } t_vote;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [SCORE_W-1:0]    cfg_data = '0;

    sliding_window_label_vote_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // vote model state
    logic [SCORE_W-1:0] vote_threshold = THRESH_RESET;
    logic [VOTES_W-1:0] vote_min       = VOTES_RESET;
    logic [LABEL_W-1:0] window_label [WINDOW_LEN];
    logic [SCORE_W-1:0] window_score [WINDOW_LEN];
    logic [FILL_W-1:0]  window_fill = '0;
    logic [SLOT_W-1:0]  window_oldest = '0;
    logic [CNT_W-1:0]   hist_count [LABEL_COUNT] = '{default: '0};
    logic [SUM_W-1:0]   hist_sum   [LABEL_COUNT] = '{default: '0};

    t_item pending_items [$];
    t_vote expected_votes [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int items_queued   = 0;
    int items_accepted = 0;
    int votes_checked  = 0;
    int recognitions   = 0;
    int saturated      = 0;
    int mismatches     = 0;
    int cycles         = 0;

    function automatic void clear_window();
        window_fill   = '0;
        window_oldest = '0;
        hist_count    = '{default: '0};
        hist_sum      = '{default: '0};
    endfunction

    function automatic t_vote predict_vote(input logic [LABEL_W-1:0] lab,
                                           input logic [SCORE_W-1:0] score_in);
        t_vote              res;
        logic [SCORE_W-1:0] sc;
        logic [LABEL_W-1:0] old_lab;
        logic [LABEL_W-1:0] best;
        logic [CNT_W-1:0]   best_cnt;
        logic [PROD_W-1:0]  needed;
        res = '0;
        sc  = (score_in > SCORE_ONE) ? SCORE_W'(SCORE_ONE) : score_in;
        if (window_fill < WINDOW_LEN) begin
            // still filling: store only
            window_label[window_fill] = lab;
            window_score[window_fill] = sc;
            hist_count[lab] += 1'b1;
            hist_sum[lab]   += sc;
            window_fill     += 1'b1;
            return res;
        end
        old_lab = window_label[window_oldest];
        hist_count[old_lab] -= 1'b1;
        hist_sum[old_lab]   -= window_score[window_oldest];
        window_label[window_oldest] = lab;
        window_score[window_oldest] = sc;
        hist_count[lab] += 1'b1;
        hist_sum[lab]   += sc;
        window_oldest = (window_oldest == WINDOW_LEN - 1) ? '0 : window_oldest + 1'b1;
        // strict compare keeps the lowest label on a tie
        best     = '0;
        best_cnt = '0;
        for (int i = 0; i < LABEL_COUNT; i++) begin
            if (hist_count[i] > best_cnt) begin
                best_cnt = hist_count[i];
                best     = LABEL_W'(i);
            end
        end
        needed = PROD_W'(vote_threshold) * PROD_W'(best_cnt);
        if (best_cnt != 0 && best_cnt >= vote_min && PROD_W'(hist_sum[best]) >= needed) begin
            res.recognized = 1'b1;
            res.label      = best;
            clear_window();
        end
        return res;
    endfunction

    function automatic void add_item(input logic [LABEL_W-1:0] lab,
                                     input logic [SCORE_W-1:0] sc);
        t_item it;
        it.label = lab;
        it.score = sc;
        if (sc > SCORE_ONE) saturated++;
        pending_items = {pending_items, it};
        items_queued++;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCORE_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_SCORE_THRESHOLD) begin
            vote_threshold = val;
        end else if (idx == CFG_MIN_VOTES) begin
            vote_min = val[VOTES_W-1:0];
        end
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (pending_items.size() != 0 || s_tvalid || expected_votes.size() != 0);
    endtask

    // input driver
    always @(posedge clk) begin : drive
        t_item it;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_votes = {expected_votes,
                                  predict_vote(s_tdata[LABEL_W-1:0],
                                               s_tdata[LABEL_W +: SCORE_W])};
                items_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    it = pending_items[0];
                    pending_items.delete(0);
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(IN_DATA_W - LABEL_W - SCORE_W){1'b0}}, it.score, it.label};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin : watch
        t_vote want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                votes_checked++;
                if (expected_votes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("ERROR: unexpected result recognized=%0b label=%0d",
                                 m_tuser, m_tdata[LABEL_W-1:0]);
                end else begin
                    want = expected_votes[0];
                    expected_votes.delete(0);
                    if (want.recognized) recognitions++;
                    if (m_tuser !== want.recognized || m_tdata[LABEL_W-1:0] !== want.label) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"ERROR: result %0d: expected recognized=%0b label=%0d,",
                                      " got recognized=%0b label=%0d"},
                                     votes_checked, want.recognized, want.label,
                                     m_tuser, m_tdata[LABEL_W-1:0]);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_votes.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int                 thr_list   [NUM_PHASES] = '{55706, 0, 65536, 131071, 32768, 58982, 0, 0};
        int                 votes_list [NUM_PHASES] = '{25, 1, 30, 0, 15, 20, 0, 31};
        int                 dir_scores [8] = '{0, 1, 65535, 65536, 65537, 131071, 'h0AAAA, 'h15555};
        int                 target;
        int                 len;
        int                 purity;
        logic [LABEL_W-1:0] dom;
        logic [SCORE_W-1:0] sc;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: fill the window with every label and the score extremes under reset config
        for (int i = 0; i < WINDOW_LEN; i++)
            add_item(LABEL_W'(i % LABEL_COUNT), SCORE_W'(dir_scores[i % 8]));
        // first vote: counts far below the reset minimum
        add_item(LABEL_W'(LABEL_COUNT - 1), '0);
        wait_idle();
        write_reg(CFG_SCORE_THRESHOLD, '0);
        write_reg(CFG_MIN_VOTES, SCORE_W'(1));
        write_reg(CFG_UNUSED, SCORE_W'(SCORE_MAX));
        // several labels tie at the top count here
        add_item('0, SCORE_W'(SCORE_ONE));
        add_item(LABEL_W'(LABEL_COUNT - 1), SCORE_W'(SCORE_MAX));

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            if (p == 6) begin
                thr_list[p]   = $urandom_range(SCORE_ONE, 0);
                votes_list[p] = $urandom_range(WINDOW_LEN, 1);
            end
            write_reg(CFG_SCORE_THRESHOLD, SCORE_W'(thr_list[p]));
            write_reg(CFG_MIN_VOTES, SCORE_W'(votes_list[p]));
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 86; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 86; end
                default: begin src_idle_pct = 23; sink_stall_pct = 23; end
            endcase
            target = items_queued + PHASE_ITEMS;
            while (items_queued < target) begin
                if ($urandom_range(3) != 0) begin
                    // a run dominated by one label with mostly confident scores
                    dom    = LABEL_W'($urandom_range(LABEL_COUNT - 1, 0));
                    len    = $urandom_range(45, 20);
                    purity = $urandom_range(100, 70);
                    for (int k = 0; k < len; k++) begin
                        if ($urandom_range(99) < purity) begin
                            if ($urandom_range(19) == 0)
                                sc = SCORE_W'(SCORE_ONE + $urandom_range(SCORE_MAX - SCORE_ONE, 1));
                            else
                                sc = SCORE_W'($urandom_range(SCORE_ONE, 48000));
                            add_item(dom, sc);
                        end else begin
                            add_item(LABEL_W'($urandom_range(LABEL_COUNT - 1, 0)),
                                     SCORE_W'($urandom_range(SCORE_MAX, 0)));
                        end
                    end
                end else begin
                    len = $urandom_range(25, 5);
                    for (int k = 0; k < len; k++)
                        add_item(LABEL_W'($urandom_range(LABEL_COUNT - 1, 0)),
                                 SCORE_W'($urandom_range(SCORE_MAX, 0)));
                end
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (expected_votes.size() != 0) mismatches++;
        $display("Ran %0d transactions over %0d register settings and four idle patterns,",
                 items_accepted, NUM_PHASES + 2);
        $display("with %0d recognitions, %0d over-range scores and %0d mismatches.",
                 recognitions, saturated, mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
